[rtl/core/mtds_pkg.sv]
// Shared types, codes and a digit helper for the multiplexed tube display scanner.
package mtds_pkg;

  // Transaction kinds on the input channel.
  localparam logic KIND_BLINK = 1'b0;
  localparam logic KIND_SCAN  = 1'b1;

  // Display views.
  localparam logic [2:0] VIEW_TIME      = 3'd0;
  localparam logic [2:0] VIEW_DATE      = 3'd1;
  localparam logic [2:0] VIEW_WDAY_TEMP = 3'd2;
  localparam logic [2:0] VIEW_STOPWATCH = 3'd3;
  localparam logic [2:0] VIEW_ALARM     = 3'd4;

  // Alarm field code meaning that no alarm field is under edit.
  localparam logic signed [2:0] ALARM_FIELD_NONE = -3'sd1;

  // Scan slot layout: slots below the first point slot drive tubes.
  localparam logic [2:0] SLOT_POINT_FIRST  = 3'd6;
  localparam logic [2:0] SLOT_POINT_SECOND = 3'd7;
  localparam logic [2:0] SLOT_TWO_FIELD_END = 3'd4;

  // Point patterns.
  localparam logic [1:0] POINTS_NONE   = 2'b00;
  localparam logic [1:0] POINTS_FIRST  = 2'b01;
  localparam logic [1:0] POINTS_SECOND = 2'b10;

  // Pair code that matches no tube pair.
  localparam logic [1:0] PAIR_NONE = 2'd3;

  // Last blink delay count that keeps the on phase; a higher count ends it.
  localparam logic [1:0] BLINK_DELAY_LAST = 2'd1;

  // Fields of a scan transaction held for the result stage.
  typedef struct packed {
    logic [2:0]        view_mode;
    logic              editing;
    logic [2:0]        edit_field;
    logic signed [2:0] alarm_edit_field;
    logic              alarm_armed;
    logic signed [7:0] value_left;
    logic signed [7:0] value_middle;
    logic signed [7:0] value_right;
  } scan_item_t;

  // Sequencer state seen by a scan transaction.
  typedef struct packed {
    logic [2:0] slot;
    logic       blink_on;
  } scan_ctrl_t;

  // One result transaction.
  typedef struct packed {
    logic [5:0] tube_enable;
    logic [3:0] digit_code;
    logic [1:0] point_bits;
    logic [2:0] scan_slot;
  } scan_result_t;

  // Decimal digit of a value 0..127: tens (modulo 10) or ones.
  // Division by ten is a multiply by 205 and a shift by 11, exact below 1024.
  function automatic logic [3:0] decimal_digit(input logic [6:0] v, input logic tens);
    logic [14:0] prod;
    logic [3:0]  tens_full;
    logic [6:0]  tens_x10;
    logic [6:0]  ones_full;
    prod      = {8'd0, v} * 15'd205;
    tens_full = prod[14:11];
    tens_x10  = {3'd0, tens_full} * 7'd10;
    ones_full = v - tens_x10;
    if (tens) begin
      decimal_digit = (tens_full >= 4'd10) ? (tens_full - 4'd10) : tens_full;
    end else begin
      decimal_digit = ones_full[3:0];
    end
  endfunction

endpackage

[rtl/core/mtds_seq.sv]
// Scan slot counter and blink phase sequencer.
module mtds_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic                kind,
  output mtds_pkg::scan_ctrl_t ctrl
);
  import mtds_pkg::*;

  logic [2:0] slot_r, slot_nxt;
  logic       phase_r, phase_nxt;
  logic [1:0] delay_r, delay_nxt;

  // State before the current transaction takes effect.
  assign ctrl.slot     = slot_r;
  assign ctrl.blink_on = phase_r;

  // Blink ticks step the phase; scan ticks step the slot.
  always_comb begin
    slot_nxt  = slot_r;
    phase_nxt = phase_r;
    delay_nxt = delay_r;
    if (accept) begin
      if (kind == KIND_SCAN) begin
        slot_nxt = slot_r + 3'd1;
      end else if (!phase_r) begin
        phase_nxt = 1'b1;
      end else if (delay_r > BLINK_DELAY_LAST) begin
        phase_nxt = 1'b0;
        delay_nxt = 2'd0;
      end else begin
        delay_nxt = delay_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r  <= 3'd0;
      phase_r <= 1'b0;
      delay_r <= 2'd0;
    end else begin
      slot_r  <= slot_nxt;
      phase_r <= phase_nxt;
      delay_r <= delay_nxt;
    end
  end

  // The delay never passes the end-of-phase count.
  a_delay_range: assert property (@(posedge clk) disable iff (!rst_n)
    delay_r != 2'd3)
    else $error("blink delay out of range");

  // The delay only counts while the phase is on.
  a_delay_off: assert property (@(posedge clk) disable iff (!rst_n)
    !phase_r |-> delay_r == 2'd0)
    else $error("blink delay nonzero in off phase");

  // A scan transaction always advances the slot by one.
  a_slot_step: assert property (@(posedge clk) disable iff (!rst_n)
    accept && kind == KIND_SCAN |=> slot_r == $past(slot_r) + 3'd1)
    else $error("scan slot did not advance");

endmodule

[rtl/core/mtds_slot_dec.sv]
// Combinational decode of one scan slot into tube enable, digit and points.
module mtds_slot_dec (
  input  mtds_pkg::scan_item_t   item,
  input  mtds_pkg::scan_ctrl_t   ctrl,
  output mtds_pkg::scan_result_t result
);
  import mtds_pkg::*;

  logic [1:0]        pair;
  logic [1:0]        want;
  logic [5:0]        slot_bit;
  logic              tube_slot;
  logic [5:0]        en_blink;
  logic signed [7:0] value_sel;
  logic [3:0]        digit;

  assign pair      = ctrl.slot[2:1];
  assign tube_slot = ctrl.slot < SLOT_POINT_FIRST;
  assign slot_bit  = tube_slot ? (6'd1 << ctrl.slot) : 6'd0;

  // Pair under clock or date edit.
  always_comb begin
    case (item.edit_field) inside
      3'd0, 3'd3:       want = 2'd0;
      3'd1, 3'd4, 3'd6: want = 2'd1;
      3'd2, 3'd5:       want = 2'd2;
      default:          want = PAIR_NONE;
    endcase
  end

  // Blink rules for the tube enable, in order of priority.
  always_comb begin
    if (item.editing && ctrl.blink_on) begin
      en_blink = (want == pair) ? slot_bit : 6'd0;
    end else if (item.view_mode == VIEW_ALARM && item.alarm_edit_field != ALARM_FIELD_NONE
                 && ctrl.blink_on) begin
      en_blink = (item.alarm_edit_field == {1'b0, pair}) ? slot_bit : 6'd0;
    end else if (item.view_mode == VIEW_ALARM && !item.alarm_armed && ctrl.blink_on) begin
      en_blink = 6'd0;
    end else begin
      en_blink = slot_bit;
    end
  end

  // Value feeding the current pair; the two-field view uses the same mapping on its tubes.
  always_comb begin
    case (pair)
      2'd0:    value_sel = item.value_right;
      2'd1:    value_sel = item.value_middle;
      default: value_sel = item.value_left;
    endcase
  end

  assign digit = decimal_digit(value_sel[6:0], ctrl.slot[0]);

  // Layout per view: digits, blanking and point bits.
  always_comb begin
    result.scan_slot   = ctrl.slot;
    result.tube_enable = en_blink;
    result.digit_code  = 4'd0;
    result.point_bits  = POINTS_NONE;
    unique case (item.view_mode) inside
      VIEW_TIME, VIEW_DATE, VIEW_STOPWATCH, VIEW_ALARM: begin
        if (tube_slot) begin
          if (value_sel[7]) begin
            result.tube_enable = 6'd0;
          end else begin
            result.digit_code = digit;
          end
        end else begin
          result.point_bits = (ctrl.slot == SLOT_POINT_FIRST) ? POINTS_FIRST : POINTS_SECOND;
        end
      end
      VIEW_WDAY_TEMP: begin
        if (ctrl.slot < SLOT_TWO_FIELD_END) begin
          if (value_sel[7]) begin
            result.tube_enable = 6'd0;
          end else begin
            result.digit_code = digit;
          end
        end else if (tube_slot) begin
          result.tube_enable = 6'd0;
        end else if (ctrl.slot == SLOT_POINT_SECOND) begin
          result.point_bits = POINTS_SECOND;
        end
      end
      default: begin
        result.digit_code = 4'd0;
      end
    endcase
  end

endmodule

[rtl/core/multiplexed_tube_display_scanner.sv]
// Top level of the multiplexed tube display scanner: input stage, sequencer and result register.
//
// Channel | Direction | Payload
// in_     | input     | kind, view_mode, editing, edit_field, alarm_edit_field, alarm_armed,
//         |           | value_left, value_middle, value_right
// out_    | output    | tube_enable, digit_code, point_bits, scan_slot
//
// Every transaction is accepted in one cycle; one may be taken every cycle.
// A scan transaction's result reaches the output through the input stage register, which takes
// it at the accepting edge, and then the output register, which takes it once the output is free or being taken.
// Blink transactions yield nothing.
// Reset clears the slot counter, blink phase and delay, and both stage valid flags.
// A stalled output holds its result; the input stage keeps taking transactions while
// either stage is free or the output is being taken.
module multiplexed_tube_display_scanner (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_kind,
  input  logic [2:0]        in_view_mode,
  input  logic              in_editing,
  input  logic [2:0]        in_edit_field,
  input  logic signed [2:0] in_alarm_edit_field,
  input  logic              in_alarm_armed,
  input  logic signed [7:0] in_value_left,
  input  logic signed [7:0] in_value_middle,
  input  logic signed [7:0] in_value_right,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [5:0]        out_tube_enable,
  output logic [3:0]        out_digit_code,
  output logic [1:0]        out_point_bits,
  output logic [2:0]        out_scan_slot
);
  import mtds_pkg::*;

  scan_ctrl_t   ctrl_cur;
  scan_ctrl_t   s1_ctrl_r;
  scan_item_t   s1_item_r;
  logic         s1_valid_r;
  logic         s1_adv;
  logic         in_acc;
  logic         scan_acc;
  scan_result_t res_nxt;
  scan_result_t out_res_r;
  logic         out_valid_r;

  // Handshake: each stage moves when the one after it is free or draining.
  assign s1_adv   = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;
  assign scan_acc = in_acc && (in_kind == KIND_SCAN);

  // Slot and blink sequencer.
  mtds_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_acc),
    .kind   (in_kind),
    .ctrl   (ctrl_cur)
  );

  // Input stage: scan transactions with the sequencer state they saw.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= scan_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_acc) begin
      s1_ctrl_r                  <= ctrl_cur;
      s1_item_r.view_mode        <= in_view_mode;
      s1_item_r.editing          <= in_editing;
      s1_item_r.edit_field       <= in_edit_field;
      s1_item_r.alarm_edit_field <= in_alarm_edit_field;
      s1_item_r.alarm_armed      <= in_alarm_armed;
      s1_item_r.value_left       <= in_value_left;
      s1_item_r.value_middle     <= in_value_middle;
      s1_item_r.value_right      <= in_value_right;
    end
  end

  // Slot decode.
  mtds_slot_dec u_slot_dec (
    .item   (s1_item_r),
    .ctrl   (s1_ctrl_r),
    .result (res_nxt)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_tube_enable = out_res_r.tube_enable;
  assign out_digit_code  = out_res_r.digit_code;
  assign out_point_bits  = out_res_r.point_bits;
  assign out_scan_slot   = out_res_r.scan_slot;

  // At most one tube is lit in any result.
  a_onehot_tube: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0(out_res_r.tube_enable))
    else $error("more than one tube enabled");

  // Point slots never light a tube or carry a digit.
  a_point_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.scan_slot >= SLOT_POINT_FIRST
      |-> out_res_r.tube_enable == 6'd0 && out_res_r.digit_code == 4'd0)
    else $error("tube lit in a point slot");

  // Digits stay decimal.
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_res_r.digit_code <= 4'd9)
    else $error("digit code not decimal");

  // A lit tube matches the slot number.
  a_tube_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.tube_enable != 6'd0
      |-> out_res_r.tube_enable == (6'd1 << out_res_r.scan_slot))
    else $error("lit tube does not match slot");

endmodule
